>>> rtl/core/gregorian_date_to_day_count_unit_defines.svh
// Assertion macros for the checker file of this block.
`ifndef GREGORIAN_DATE_TO_DAY_COUNT_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_TO_DAY_COUNT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define GDC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define GDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/gdc_pkg.sv
package gdc_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;

  localparam logic [YEAR_W-1:0]  YEAR_MAX = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS = DAY_W'(29);
  localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;

  // floor(x / 100) = (x * 5243) >> 19, exact for every x below 43699.
  localparam int unsigned DIV100_MUL_W = 13;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned DIV100_PROD_W = YEAR_W + DIV100_MUL_W;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = DIV100_MUL_W'(5243);
  localparam int unsigned Q100_W = DIV100_PROD_W - DIV100_SHIFT;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
  } gdc_date_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_number;
    logic               invalid;
  } gdc_result_t;

  function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] x);
    logic [DIV100_PROD_W-1:0] prod;
    prod = DIV100_PROD_W'(x) * DIV100_PROD_W'(DIV100_MUL);
    return prod[DIV100_PROD_W-1:DIV100_SHIFT];
  endfunction

  // Days in the whole months before the given month of a common year.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Month length in a common year; zero for a month code that means nothing.
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
      4'd2:                                      d = 5'd28;
      default:                                   d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/gdc_calc.sv
module gdc_calc (
  input  gdc_pkg::gdc_date_t   date,
  output gdc_pkg::gdc_result_t result
);

  logic [gdc_pkg::YEAR_W-1:0]  prior;
  logic [gdc_pkg::Q100_W-1:0]  y_q100;
  logic [gdc_pkg::Q100_W-1:0]  p_q100;
  logic [gdc_pkg::Q100_W-3:0]  y_q400;
  logic [gdc_pkg::Q100_W-3:0]  p_q400;
  logic                        div100;
  logic                        div400;
  logic                        leap;
  logic                        year_ok;
  logic                        month_ok;
  logic                        day_ok;
  logic [gdc_pkg::DAY_W-1:0]   max_day;
  logic [gdc_pkg::COUNT_W-1:0] year_days;
  logic [gdc_pkg::COUNT_W-1:0] count;

  assign prior  = date.year - gdc_pkg::YEAR_W'(1);
  assign y_q100 = gdc_pkg::div100(date.year);
  assign p_q100 = gdc_pkg::div100(prior);
  assign y_q400 = y_q100[gdc_pkg::Q100_W-1:2];
  assign p_q400 = p_q100[gdc_pkg::Q100_W-1:2];

  // A multiple of 100 (or 400) is exactly where the quotient steps up from the
  // previous year.
  assign div100 = (y_q100 != p_q100);
  assign div400 = (y_q400 != p_q400);
  assign leap   = div400 || ((date.year[1:0] == 2'b00) && !div100);

  assign year_ok  = (date.year != '0) && (date.year <= gdc_pkg::YEAR_MAX);
  assign month_ok = (date.month >= gdc_pkg::MONTH_JAN) && (date.month <= gdc_pkg::MONTH_DEC);

  always_comb begin
    max_day = gdc_pkg::month_length(date.month);
    if (leap && (date.month == gdc_pkg::MONTH_FEB)) begin
      max_day = gdc_pkg::FEB_LEAP_DAYS;
    end
  end

  assign day_ok = (date.day_of_month != '0) && (date.day_of_month <= max_day);

  assign year_days = gdc_pkg::COUNT_W'(prior) * gdc_pkg::COUNT_W'(gdc_pkg::DAYS_PER_YEAR);

  assign count = year_days
               + gdc_pkg::COUNT_W'(prior[gdc_pkg::YEAR_W-1:2])
               - gdc_pkg::COUNT_W'(p_q100)
               + gdc_pkg::COUNT_W'(p_q400)
               + gdc_pkg::COUNT_W'(gdc_pkg::days_before_month(date.month))
               + gdc_pkg::COUNT_W'(leap && (date.month > gdc_pkg::MONTH_FEB))
               + gdc_pkg::COUNT_W'(date.day_of_month);

  always_comb begin
    if (year_ok && month_ok && day_ok) begin
      result.day_number = count;
      result.invalid    = 1'b0;
    end else begin
      result.day_number = '0;
      result.invalid    = 1'b1;
    end
  end

endmodule

>>> rtl/core/gregorian_date_to_day_count_unit.sv
// An accepted input transaction passes the input register, then the result register,
// where out_valid rises. Throughput: one transaction per cycle while out_stall is low,
// set by the single registered pass through the date arithmetic; a stalled result holds
// both registers once both are full.
// Reset: synchronous on rst_n low; both valid flags clear and in_stall is held high.
module gregorian_date_to_day_count_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [gdc_pkg::YEAR_W-1:0]      in_year,
  input  logic [gdc_pkg::MONTH_W-1:0]     in_month,
  input  logic [gdc_pkg::DAY_W-1:0]       in_day_of_month,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gdc_pkg::COUNT_W-1:0]     out_day_number,
  output logic                            out_invalid
);

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  gdc_pkg::gdc_date_t   s1_date_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  gdc_pkg::gdc_result_t out_res_r;
  gdc_pkg::gdc_result_t calc_res;
  logic                 out_open;
  logic                 s1_open;
  logic                 in_take;

  gdc_calc u_calc (
    .date   (s1_date_r),
    .result (calc_res)
  );

  // The result register frees when empty or when its transaction leaves this cycle.
  assign out_open = !out_valid_r || !out_stall;
  assign s1_open  = !s1_valid_r || out_open;
  assign in_stall = !rst_n || !s1_open;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_open) begin
      s1_valid_nxt = in_take;
    end
    out_valid_nxt = out_valid_r;
    if (out_open) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_date_r.year         <= in_year;
      s1_date_r.month        <= in_month;
      s1_date_r.day_of_month <= in_day_of_month;
    end
    if (out_open && s1_valid_r) begin
      out_res_r <= calc_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_day_number = out_res_r.day_number;
  assign out_invalid    = out_res_r.invalid;

endmodule

>>> rtl/core/gdc_checker.sv
`include "gregorian_date_to_day_count_unit_defines.svh"

module gdc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [gdc_pkg::COUNT_W-1:0] out_day_number,
  input logic                        out_invalid
);

  localparam logic [gdc_pkg::COUNT_W-1:0] DAY_NUMBER_MAX = gdc_pkg::COUNT_W'(3652059);

  logic                      out_bad;
  logic                      out_good;
  logic                      out_held;
  logic                      result_zero;
  logic                      result_in_range;
  logic [gdc_pkg::COUNT_W:0] out_result;

  assign out_bad         = out_valid && out_invalid;
  assign out_good        = out_valid && !out_invalid;
  assign out_held        = out_valid && out_stall;
  assign result_zero     = (out_day_number == '0);
  assign result_in_range = !result_zero && (out_day_number <= DAY_NUMBER_MAX);
  assign out_result      = {out_day_number, out_invalid};

  `GDC_ASSERT_SAME(a_invalid_zero, out_bad, result_zero, "invalid result not zero")
  `GDC_ASSERT_SAME(a_valid_range, out_good, result_in_range, "day number out of range")
  `GDC_ASSERT_SAME(a_empty_no_stall, !out_valid, !in_stall, "input stalled while empty")
  `GDC_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_result), "result moved")

endmodule

bind gregorian_date_to_day_count_unit gdc_checker u_gdc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_day_number (out_day_number),
  .out_invalid    (out_invalid)
);

>>> verif/gregorian_date_to_day_count_unit_tb.sv
module gregorian_date_to_day_count_unit_tb;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned RANDOM_DATES = 1450;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned HOLD_CYCLES  = 250;

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          in_valid        = 1'b0;
  logic                          in_stall;
  logic [gdc_pkg::YEAR_W-1:0]    in_year         = '0;
  logic [gdc_pkg::MONTH_W-1:0]   in_month        = '0;
  logic [gdc_pkg::DAY_W-1:0]     in_day_of_month = '0;
  logic                          out_valid;
  logic                          out_stall       = 1'b0;
  logic [gdc_pkg::COUNT_W-1:0]   out_day_number;
  logic                          out_invalid;

  gdc_pkg::gdc_date_t   pending_dates[$];
  gdc_pkg::gdc_result_t awaited_counts[$];
  gdc_pkg::gdc_date_t   next_date;

  int unsigned error_count    = 0;
  int unsigned counts_checked = 0;
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_mode     = 0;
  int unsigned mode_left      = 0;
  int unsigned hold_left      = 0;
  int unsigned next_hold_at   = 300;

  gregorian_date_to_day_count_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_year         (in_year),
    .in_month        (in_month),
    .in_day_of_month (in_day_of_month),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_day_number  (out_day_number),
    .out_invalid     (out_invalid)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  // Length of a month in the given year; zero for a month number outside 1..12.
  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic gdc_pkg::gdc_result_t ordinal_of_date(
    input logic [gdc_pkg::YEAR_W-1:0]  y,
    input logic [gdc_pkg::MONTH_W-1:0] m,
    input logic [gdc_pkg::DAY_W-1:0]   d
  );
    gdc_pkg::gdc_result_t r;
    int unsigned prior;
    int unsigned count;
    r.day_number = '0;
    r.invalid    = 1'b1;
    if (y == 0 || y > gdc_pkg::YEAR_MAX) return r;
    if (m < gdc_pkg::MONTH_JAN || m > gdc_pkg::MONTH_DEC) return r;
    if (d == 0 || d > days_in_month(y, m)) return r;
    prior = y - 1;
    count = prior * 365 + prior / 4 - prior / 100 + prior / 400;
    // Whole months before this one, with February taken at its length in this year.
    for (int unsigned k = 1; k < m; k++) count += days_in_month(y, k);
    count += d;
    r.day_number = gdc_pkg::COUNT_W'(count);
    r.invalid    = 1'b0;
    return r;
  endfunction

  task automatic queue_date(input int unsigned y, input int unsigned m, input int unsigned d);
    gdc_pkg::gdc_date_t dt;
    dt.year         = gdc_pkg::YEAR_W'(y);
    dt.month        = gdc_pkg::MONTH_W'(m);
    dt.day_of_month = gdc_pkg::DAY_W'(d);
    pending_dates.push_back(dt);
  endtask

  function automatic int unsigned pick_valid_year();
    int unsigned sel;
    int unsigned y;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      y = $urandom_range(1, 9999);
    end else if (sel < 70) begin
      // Century boundaries are where the leap rule changes.
      y = $urandom_range(1, 99) * 100 + $urandom_range(0, 2);
      y = (y == 0) ? 1 : y - 1;
      if (y > 9999) y = 9999;
    end else if (sel < 85) begin
      y = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 12) : $urandom_range(9988, 9999);
    end else begin
      y = $urandom_range(1990, 2010);
    end
    return y;
  endfunction

  task automatic queue_random_date();
    int unsigned y;
    int unsigned m;
    int unsigned len;
    int unsigned sel;
    y   = pick_valid_year();
    m   = $urandom_range(1, 12);
    len = days_in_month(y, m);
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      queue_date(y, m, $urandom_range(1, len));
    end else if (sel < 75) begin
      queue_date(y, m, ($urandom_range(0, 1) == 0) ? len : 1);
    end else if (sel < 80) begin
      queue_date(y, 2, 29);
    end else if (sel < 88) begin
      // Near misses: a day just outside the month.
      queue_date(y, m, ($urandom_range(0, 1) == 0) ? len + 1 : 0);
    end else begin
      queue_date($urandom_range(0, (1 << gdc_pkg::YEAR_W) - 1),
                 $urandom_range(0, (1 << gdc_pkg::MONTH_W) - 1),
                 $urandom_range(0, (1 << gdc_pkg::DAY_W) - 1));
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_counts.push_back(ordinal_of_date(in_year, in_month, in_day_of_month));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_dates.size() != 0) begin
          next_date = pending_dates.pop_front();
          in_year         <= next_date.year;
          in_month        <= next_date.month;
          in_day_of_month <= next_date.day_of_month;
          in_valid        <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction and stalls on a pattern of its own.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_counts.size() == 0) begin
          $error("unexpected result: day_number %0d invalid %0b", out_day_number, out_invalid);
          error_count++;
        end else begin
          if (out_day_number !== awaited_counts[0].day_number) begin
            $error("day_number: expected %0d, actual %0d",
                   awaited_counts[0].day_number, out_day_number);
            error_count++;
          end
          if (out_invalid !== awaited_counts[0].invalid) begin
            $error("invalid: expected %0b, actual %0b", awaited_counts[0].invalid, out_invalid);
            error_count++;
          end
          void'(awaited_counts.pop_front());
          counts_checked++;
        end
      end

      // A long hold-off now and then lets the pipeline fill and push back on the sender.
      if (counts_checked >= next_hold_at) begin
        hold_left    = HOLD_CYCLES;
        next_hold_at = next_hold_at + 700;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end

      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 30);
          2:       out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin
    // Extremes of the range and of each field.
    queue_date(1, 1, 1);
    queue_date(9999, 12, 31);
    queue_date(0, 1, 1);
    queue_date(10000, 1, 1);
    queue_date((1 << gdc_pkg::YEAR_W) - 1, (1 << gdc_pkg::MONTH_W) - 1,
               (1 << gdc_pkg::DAY_W) - 1);
    queue_date(2000, 0, 10);
    queue_date(2000, 13, 10);
    queue_date(2000, 15, 10);
    queue_date(2000, 5, 0);
    queue_date(2000, 4, 31);
    queue_date(2001, 1, 31);
    // Leap rule around February, including century years.
    queue_date(2000, 2, 29);
    queue_date(1900, 2, 29);
    queue_date(1900, 2, 28);
    queue_date(2004, 2, 29);
    queue_date(2001, 2, 29);
    queue_date(2000, 3, 1);
    queue_date(1900, 3, 1);
    queue_date(2000, 12, 31);
    queue_date(1999, 12, 31);
    queue_date(400, 12, 31);
    queue_date(100, 3, 1);
    queue_date(9999, 12, 32);
    queue_date(2023, 11, 30);
    for (int unsigned i = 0; i < RANDOM_DATES; i++) queue_random_date();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled away from the rising edge so the sender's updates for that edge are settled.
    while (pending_dates.size() != 0 || in_valid || awaited_counts.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_counts.size() != 0) begin
      $error("%0d results never arrived", awaited_counts.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("gregorian_date_to_day_count_unit_tb: done, clean");
    end else begin
      $display("gregorian_date_to_day_count_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("gregorian_date_to_day_count_unit_tb: done, errors");
    $finish;
  end

endmodule
